// File: hw/rtl/lz10_pkg.sv
// Shared types and constants for the LZ77 type-10 decompressor.
package lz10_pkg;

    // Default history depth in bytes.
    localparam int HIST_DEPTH_DEF = 4096;

    // Header type nibble that marks an LZ77 type-10 stream.
    localparam logic [3:0] TYPE_ID = 4'h1;

    // Tokens governed by one flag byte.
    localparam logic [3:0] FLAG_TOKENS = 4'd8;

    // Bias added to the length nibble of a back-reference.
    localparam logic [4:0] LEN_BIAS = 5'd3;

    // Result status codes.
    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
    localparam logic [1:0] ST_ZERO_SIZE = 2'd2;

    // What the next stream byte means.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_FLAG   = 2'd1,
        PH_TOKEN  = 2'd2,
        PH_MATCH2 = 2'd3
    } t_phase;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_IN    = 3'b001,
        S_PRIME = 3'b010,
        S_COPY  = 3'b100
    } t_state;

endpackage

// File: hw/rtl/lz77_type10_decompressor_top.sv
// LZ77 type-10 stream decompressor with an on-chip history memory.
//
// The input channel carries one compressed byte per beat; i_first_byte marks
// the first header byte of a stream and restarts decoding. The output channel
// carries one result per beat: a decompressed byte, or a header error status.
// Header, flag and match-first bytes give no result, but the last byte of a
// bad header gives an error status. A literal byte's result sits in the
// output register in the cycle after it is accepted. A back-reference's
// second byte starts a copy: a prime step issues the history read, then one
// byte per cycle leaves while the receiver does not stall, for the copy
// length of 3 to 18 bytes, fewer when the declared size is reached first.
// The single history memory, read and written once per cycle, sets the copy
// rate; a distance of one is served by forwarding the byte just written.
// Reset returns the decoder to idle; the history memory is not cleared and
// needs no pass. When the receiver stalls, the output register holds its beat,
// a running copy pauses in place, and the input channel stalls in turn.
module lz77_type10_decompressor_top
    import lz10_pkg::*;
#(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_first_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_last_of_run,
    output logic       o_end_of_stream
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW-1:0] HIST_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW:0]   HIST_SPAN = (AW+1)'(HISTORY_DEPTH);

    // Control and stream registers.
    t_state      r_state,  n_state;
    t_phase      r_phase,  n_phase;
    logic        r_active, n_active;
    logic [1:0]  r_hidx,   n_hidx;
    logic [23:0] r_total,  n_total;
    logic [23:0] r_count,  n_count;
    logic [7:0]  r_shift,  n_shift;
    logic [3:0]  r_left,   n_left;
    logic [7:0]  r_mfirst, n_mfirst;
    logic [4:0]  r_copy_left, n_copy_left;
    logic [12:0] r_dist,   n_dist;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic [1:0]  r_out_status, n_out_status;
    logic        r_out_last,  n_out_last;
    logic        r_out_eos,   n_out_eos;

    // History memory and its forwarding path.
    logic [7:0]    r_hist [HISTORY_DEPTH];
    logic [7:0]    r_rdata;
    logic          r_fwd;
    logic [7:0]    r_fwd_byte;
    logic          hist_we;
    logic [AW-1:0] hist_raddr;
    logic [7:0]    hist_wdata;

    logic          can_emit;
    logic          in_acc;
    logic [23:0]   cnt_inc;
    logic [AW:0]   back_diff;
    logic [AW-1:0] wptr_inc;
    logic [AW-1:0] rptr_inc;
    logic [7:0]    copy_src;
    logic [7:0]    copy_byte;
    logic          copy_eos;

    // The output register can take a beat when empty or draining.
    assign can_emit   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IN) && can_emit);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign cnt_inc   = r_count + 24'd1;
    assign wptr_inc  = (r_wptr == HIST_LAST) ? '0 : r_wptr + AW'(1);
    assign rptr_inc  = (r_rptr == HIST_LAST) ? '0 : r_rptr + AW'(1);
    assign back_diff = {1'b0, r_wptr} - (AW+1)'(r_dist);

    // Copy data: forwarded byte for distance one, zero before the stream start.
    assign copy_src  = r_fwd ? r_fwd_byte : r_rdata;
    assign copy_byte = (r_count >= {11'd0, r_dist}) ? copy_src : 8'd0;
    assign copy_eos  = (cnt_inc == r_total);

    // Next-state logic for the decoder.
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_active     = r_active;
        n_hidx       = r_hidx;
        n_total      = r_total;
        n_count      = r_count;
        n_shift      = r_shift;
        n_left       = r_left;
        n_mfirst     = r_mfirst;
        n_copy_left  = r_copy_left;
        n_dist       = r_dist;
        n_wptr       = r_wptr;
        n_rptr       = r_rptr;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_byte   = r_out_byte;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_eos    = r_out_eos;
        hist_we      = 1'b0;
        hist_wdata   = copy_byte;
        hist_raddr   = r_rptr;

        case (r_state)
            S_IN: begin
                if (in_acc && i_first_byte) begin
                    // Restart: this byte is header byte zero.
                    n_active = 1'b1;
                    n_phase  = PH_HEADER;
                    n_hidx   = 2'd1;
                    n_total  = '0;
                    n_count  = '0;
                    n_shift  = '0;
                    n_left   = '0;
                    n_mfirst = i_in_byte;
                    n_wptr   = '0;
                end else if (in_acc && r_active) begin
                    case (r_phase)
                        PH_HEADER: begin
                            case (r_hidx)
                                2'd0:    n_mfirst = i_in_byte;
                                2'd1:    n_total[7:0] = i_in_byte;
                                2'd2:    n_total[15:8] = i_in_byte;
                                default: n_total[23:16] = i_in_byte;
                            endcase
                            n_hidx = r_hidx + 2'd1;
                            if (r_hidx == 2'd3) begin
                                if (r_mfirst[7:4] != TYPE_ID) begin
                                    n_out_valid  = 1'b1;
                                    n_out_byte   = '0;
                                    n_out_status = ST_BAD_TYPE;
                                    n_out_last   = 1'b1;
                                    n_out_eos    = 1'b0;
                                    n_active     = 1'b0;
                                end else if (n_total == 24'd0) begin
                                    n_out_valid  = 1'b1;
                                    n_out_byte   = '0;
                                    n_out_status = ST_ZERO_SIZE;
                                    n_out_last   = 1'b1;
                                    n_out_eos    = 1'b0;
                                    n_active     = 1'b0;
                                end else begin
                                    n_count = '0;
                                    n_phase = PH_FLAG;
                                end
                            end
                        end
                        PH_FLAG: begin
                            n_shift = i_in_byte;
                            n_left  = FLAG_TOKENS;
                            n_phase = PH_TOKEN;
                        end
                        PH_TOKEN: begin
                            if (!r_shift[7]) begin
                                // Literal byte: emit, record, close the token.
                                hist_we      = 1'b1;
                                hist_wdata   = i_in_byte;
                                n_wptr       = wptr_inc;
                                n_count      = cnt_inc;
                                n_out_valid  = 1'b1;
                                n_out_byte   = i_in_byte;
                                n_out_status = ST_DATA;
                                n_out_last   = 1'b1;
                                n_out_eos    = (cnt_inc == r_total);
                                n_shift      = {r_shift[6:0], 1'b0};
                                n_left       = r_left - 4'd1;
                                if (cnt_inc >= r_total) begin
                                    n_active = 1'b0;
                                    n_phase  = PH_HEADER;
                                end else if (r_left == 4'd1) begin
                                    n_phase = PH_FLAG;
                                end else begin
                                    n_phase = PH_TOKEN;
                                end
                            end else begin
                                n_mfirst = i_in_byte;
                                n_phase  = PH_MATCH2;
                            end
                        end
                        default: begin
                            // Second byte of a back-reference: start the copy.
                            n_copy_left = {1'b0, r_mfirst[7:4]} + LEN_BIAS;
                            n_dist      = {r_mfirst[3:0], i_in_byte} + 13'd1;
                            n_state     = S_PRIME;
                        end
                    endcase
                end
            end
            S_PRIME: begin
                // Point the read at the first source byte and issue it.
                if (back_diff[AW]) begin
                    hist_raddr = AW'(back_diff + HIST_SPAN);
                end else begin
                    hist_raddr = back_diff[AW-1:0];
                end
                n_rptr  = hist_raddr;
                n_state = S_COPY;
            end
            S_COPY: begin
                if (can_emit) begin
                    hist_we      = 1'b1;
                    hist_wdata   = copy_byte;
                    hist_raddr   = rptr_inc;
                    n_rptr       = rptr_inc;
                    n_wptr       = wptr_inc;
                    n_count      = cnt_inc;
                    n_copy_left  = r_copy_left - 5'd1;
                    n_out_valid  = 1'b1;
                    n_out_byte   = copy_byte;
                    n_out_status = ST_DATA;
                    n_out_eos    = copy_eos;
                    n_out_last   = copy_eos || (r_copy_left == 5'd1);
                    if (copy_eos || (r_copy_left == 5'd1)) begin
                        n_state = S_IN;
                        n_shift = {r_shift[6:0], 1'b0};
                        n_left  = r_left - 4'd1;
                        if (copy_eos) begin
                            n_active = 1'b0;
                            n_phase  = PH_HEADER;
                        end else if (r_left == 4'd1) begin
                            n_phase = PH_FLAG;
                        end else begin
                            n_phase = PH_TOKEN;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_phase     <= PH_HEADER;
            r_active    <= 1'b0;
            r_hidx      <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_shift     <= '0;
            r_left      <= '0;
            r_mfirst    <= '0;
            r_copy_left <= '0;
            r_dist      <= '0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_active    <= n_active;
            r_hidx      <= n_hidx;
            r_total     <= n_total;
            r_count     <= n_count;
            r_shift     <= n_shift;
            r_left      <= n_left;
            r_mfirst    <= n_mfirst;
            r_copy_left <= n_copy_left;
            r_dist      <= n_dist;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_out_valid <= n_out_valid;
            r_fwd       <= hist_we && (hist_raddr == r_wptr);
        end
    end

    // Output payload and forwarded byte.
    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_eos    <= n_out_eos;
        r_fwd_byte   <= hist_wdata;
    end

    // History memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[r_wptr] <= hist_wdata;
        end
        r_rdata <= r_hist[hist_raddr];
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_status        = r_out_status;
    assign o_last_of_run   = r_out_last;
    assign o_end_of_stream = r_out_eos;

    // A running copy always has bytes left and room under the declared size.
    a_copy_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_copy_left != 5'd0) && (r_count < r_total))
        else $error("copy running past its length or the declared size");

    // Forwarding is only needed when the source is the byte just written.
    a_fwd_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd && (r_state == S_COPY)) |-> (r_dist == 13'd1))
        else $error("forwarded history byte at a distance other than one");

    // No input byte is taken while a copy is primed or running.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IN) |-> o_in_stall)
        else $error("input accepted during a copy");

    // An error result ends the run and is never the end of a stream.
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_DATA)) |-> (o_last_of_run && !o_end_of_stream))
        else $error("error beat with wrong run or stream markers");

endmodule
